FILE: hdl/integer_to_roman_numeral_defines.svh
// Assertion macros shared by the Roman numeral converter.
`ifndef INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH

// Same-cycle implication, sampled on clock and masked while reset is high.
`define ITRN_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("integer_to_roman_numeral assertion failed");

// Next-cycle implication, sampled on clock and masked while reset is high.
`define ITRN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("integer_to_roman_numeral assertion failed");

`endif

FILE: hdl/itrn_pkg.sv
// Types, constants and digit functions of the Roman numeral converter.
package itrn_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [1:0] place_type;

   typedef enum logic [1:0] {
      SYM_ONE,
      SYM_FIVE,
      SYM_TEN
   } sym_kind_type;

   localparam place_type PLACE_UNITS     = 2'd0;
   localparam place_type PLACE_TENS      = 2'd1;
   localparam place_type PLACE_HUNDREDS  = 2'd2;
   localparam place_type PLACE_THOUSANDS = 2'd3;

   localparam int unsigned NUM_WIDTH   = 12;
   localparam int unsigned NUM_PLACES  = 4;
   localparam int unsigned CHAR_WIDTH  = 7;

   localparam logic [11:0] NUM_LIMIT   = 12'd4000;
   localparam logic [11:0] THOUSAND    = 12'd1000;
   localparam logic [9:0]  HUNDRED     = 10'd100;
   localparam logic [6:0]  TEN         = 7'd10;

   localparam logic [6:0] CHAR_NONE = 7'h00;
   localparam logic [6:0] CHAR_I    = 7'h49;
   localparam logic [6:0] CHAR_V    = 7'h56;
   localparam logic [6:0] CHAR_X    = 7'h58;
   localparam logic [6:0] CHAR_L    = 7'h4C;
   localparam logic [6:0] CHAR_C    = 7'h43;
   localparam logic [6:0] CHAR_D    = 7'h44;
   localparam logic [6:0] CHAR_M    = 7'h4D;

   // Thousands digit of a value below 4000, by comparison.
   function automatic logic [1:0] thousands_digit(input logic [11:0] n);
      logic [1:0] d;
      d = 2'd0;
      for (int k = 1; k <= 3; k++) begin
         if (n >= 12'(k * 1000)) d = 2'(k);
      end
      return d;
   endfunction

   // Hundreds digit of a value below 1000.
   function automatic digit_type hundreds_digit(input logic [9:0] r);
      digit_type d;
      d = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (r >= 10'(k * 100)) d = 4'(k);
      end
      return d;
   endfunction

   // Tens digit of a value below 100.
   function automatic digit_type tens_digit(input logic [6:0] r);
      digit_type d;
      d = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (r >= 7'(k * 10)) d = 4'(k);
      end
      return d;
   endfunction

   // Number of letters that one decimal digit takes.
   function automatic logic [2:0] digit_len(input digit_type d);
      logic [2:0] len;
      unique case (d)
         4'd1, 4'd5:             len = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
         4'd3, 4'd7:             len = 3'd3;
         4'd8:                   len = 3'd4;
         default:                len = 3'd0;
      endcase
      return len;
   endfunction

   // Which of the three letters of a place stands at a position of a digit.
   function automatic sym_kind_type digit_kind(input digit_type d, input logic [1:0] pos);
      sym_kind_type k;
      if (d == 4'd9) begin
         k = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
      end else if (d >= 4'd5) begin
         k = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
      end else if (d == 4'd4) begin
         k = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
      end else begin
         k = SYM_ONE;
      end
      return k;
   endfunction

   // ASCII letter for a place and a letter kind.
   function automatic logic [6:0] place_char(input place_type place, input sym_kind_type k);
      logic [6:0] c;
      unique case (place)
         PLACE_UNITS:    c = (k == SYM_ONE) ? CHAR_I : (k == SYM_FIVE) ? CHAR_V : CHAR_X;
         PLACE_TENS:     c = (k == SYM_ONE) ? CHAR_X : (k == SYM_FIVE) ? CHAR_L : CHAR_C;
         PLACE_HUNDREDS: c = (k == SYM_ONE) ? CHAR_C : (k == SYM_FIVE) ? CHAR_D : CHAR_M;
         default:        c = CHAR_M;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/integer_to_roman_numeral.sv
// Integer to Roman numeral converter: digit pipeline, letter serializer, output register.
//
// The req_ channel takes one integer per transfer in req_tdata[11:0]. Values 1 to 3999
// come out on the rsp_ channel as their Roman numeral, one ASCII letter per transfer,
// most significant letter first, with rsp_tlast high on the final letter. A value of 0
// or of 4000 and above gives a single transfer with rsp_tdata zero and both rsp_tlast
// and rsp_tuser high.
//
// Three register stages take the value apart into thousands, hundreds, tens and units.
// A serializer then walks the digits and places one letter a cycle in the output
// register while rsp_tready does not stall it. An accepted value passes stages one,
// two, three and the serializer before its first letter reaches the output register.
// The rsp_ side moves one letter per cycle while rsp_tready is high; a numeral has 1 to
// 15 letters, 3888 the longest. The next item is loaded by the serializer in the same
// cycle as the last letter of the one before: back-to-back items leave no gap on rsp_.
//
// Reset is synchronous and clears every valid bit. When rsp_tready is low the output
// register holds its letter, the serializer waits, and the pipeline stages fill up
// before req_tready falls.
`include "integer_to_roman_numeral_defines.svh"

module integer_to_roman_numeral (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] number_in, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] symbol_char, [7] zero
   output logic        rsp_tlast,   // is_last
   output logic        rsp_tuser    // out_of_range
);

   // Stage one: thousands split off, range check.
   logic        st1_valid_ff;
   logic        st1_err_ff, st1_err_in;
   logic [1:0]  st1_thou_ff, st1_thou_in;
   logic [9:0]  st1_rem_ff, st1_rem_in;

   // Stage two: hundreds split off.
   logic        st2_valid_ff;
   logic        st2_err_ff;
   logic [1:0]  st2_thou_ff;
   itrn_pkg::digit_type st2_hund_ff, st2_hund_in;
   logic [6:0]  st2_rem_ff, st2_rem_in;

   // Stage three: all four digits, units first.
   logic        st3_valid_ff;
   logic        st3_err_ff;
   itrn_pkg::digit_type st3_dig_ff [itrn_pkg::NUM_PLACES];
   itrn_pkg::digit_type st3_tens_in, st3_units_in;

   // Serializer.
   logic                ser_busy_ff;
   logic                ser_err_ff;
   itrn_pkg::digit_type ser_dig_ff [itrn_pkg::NUM_PLACES];
   itrn_pkg::place_type ser_place_ff, ser_place_in;
   logic [1:0]          ser_pos_ff, ser_pos_in;

   // Output register.
   logic        rsp_valid_ff;
   logic [6:0]  rsp_char_ff;
   logic        rsp_last_ff;
   logic        rsp_err_ff;

   logic free1, free2, free3;
   logic emit, emit_last, ser_load, digit_end, has_lower;
   itrn_pkg::digit_type cur_digit;
   logic [2:0]          cur_len;
   itrn_pkg::place_type next_place, first_place;
   logic [6:0]          emit_char;
   logic [11:0]         num;

   // A stage takes new data when it is empty or its content moves on this cycle.
   assign free3      = !st3_valid_ff || ser_load;
   assign free2      = !st2_valid_ff || free3;
   assign free1      = !st1_valid_ff || free2;
   assign req_tready = free1;

   assign num = req_tdata[itrn_pkg::NUM_WIDTH-1:0];

   always_comb begin
      st1_err_in  = (num == 12'd0) || (num >= itrn_pkg::NUM_LIMIT);
      st1_thou_in = itrn_pkg::thousands_digit(num);
      st1_rem_in  = 10'(num - 12'(st1_thou_in) * itrn_pkg::THOUSAND);
   end

   always_comb begin
      st2_hund_in = itrn_pkg::hundreds_digit(st1_rem_ff);
      st2_rem_in  = 7'(st1_rem_ff - 10'(st2_hund_in) * itrn_pkg::HUNDRED);
   end

   always_comb begin
      st3_tens_in  = itrn_pkg::tens_digit(st2_rem_ff);
      st3_units_in = 4'(st2_rem_ff - 7'(st3_tens_in) * itrn_pkg::TEN);
   end

   // The serializer emits whenever it holds an item and the output register has room.
   assign emit      = ser_busy_ff && (!rsp_valid_ff || rsp_tready);
   assign cur_digit = ser_dig_ff[ser_place_ff];
   assign cur_len   = itrn_pkg::digit_len(cur_digit);
   assign digit_end = (3'({1'b0, ser_pos_ff}) + 3'd1) == cur_len;

   // Highest nonzero digit below the current place.
   always_comb begin
      has_lower  = 1'b0;
      next_place = itrn_pkg::PLACE_UNITS;
      for (int k = 0; k < itrn_pkg::NUM_PLACES; k++) begin
         if (2'(k) < ser_place_ff && ser_dig_ff[k] != 4'd0) begin
            has_lower  = 1'b1;
            next_place = 2'(k);
         end
      end
   end

   // Highest nonzero digit of the item waiting in stage three.
   always_comb begin
      first_place = itrn_pkg::PLACE_UNITS;
      for (int k = 0; k < itrn_pkg::NUM_PLACES; k++) begin
         if (st3_dig_ff[k] != 4'd0) first_place = 2'(k);
      end
   end

   assign emit_last = ser_err_ff || (digit_end && !has_lower);
   assign emit_char = ser_err_ff ? itrn_pkg::CHAR_NONE :
                      itrn_pkg::place_char(ser_place_ff,
                                           itrn_pkg::digit_kind(cur_digit, ser_pos_ff));
   assign ser_load  = st3_valid_ff && (!ser_busy_ff || (emit && emit_last));

   always_comb begin
      ser_place_in = ser_place_ff;
      ser_pos_in   = ser_pos_ff;
      if (ser_load) begin
         ser_place_in = first_place;
         ser_pos_in   = 2'd0;
      end else if (emit) begin
         if (digit_end) begin
            ser_place_in = next_place;
            ser_pos_in   = 2'd0;
         end else begin
            ser_pos_in = ser_pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         ser_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (free1) st1_valid_ff <= req_tvalid;
         if (free2) st2_valid_ff <= st1_valid_ff;
         if (free3) st3_valid_ff <= st2_valid_ff;
         if (ser_load) begin
            ser_busy_ff <= 1'b1;
         end else if (emit && emit_last) begin
            ser_busy_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free1) begin
         st1_err_ff  <= st1_err_in;
         st1_thou_ff <= st1_thou_in;
         st1_rem_ff  <= st1_rem_in;
      end
      if (free2) begin
         st2_err_ff  <= st1_err_ff;
         st2_thou_ff <= st1_thou_ff;
         st2_hund_ff <= st2_hund_in;
         st2_rem_ff  <= st2_rem_in;
      end
      if (free3) begin
         st3_err_ff                               <= st2_err_ff;
         st3_dig_ff[itrn_pkg::PLACE_THOUSANDS]    <= 4'(st2_thou_ff);
         st3_dig_ff[itrn_pkg::PLACE_HUNDREDS]     <= st2_hund_ff;
         st3_dig_ff[itrn_pkg::PLACE_TENS]         <= st3_tens_in;
         st3_dig_ff[itrn_pkg::PLACE_UNITS]        <= st3_units_in;
      end
      if (ser_load) begin
         ser_err_ff <= st3_err_ff;
         ser_dig_ff <= st3_dig_ff;
      end
      ser_place_ff <= ser_place_in;
      ser_pos_ff   <= ser_pos_in;
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
         rsp_err_ff  <= ser_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // An error result is a lone zero character that closes its numeral.
   `ITRN_ASSERT(a_err_single, rsp_valid_ff && rsp_err_ff,
                rsp_last_ff && rsp_char_ff == itrn_pkg::CHAR_NONE)
   // A letter of a valid numeral is never the zero code.
   `ITRN_ASSERT(a_letter_nonzero, rsp_valid_ff && !rsp_err_ff,
                rsp_char_ff != itrn_pkg::CHAR_NONE)
   // The letter position stays inside the current digit while the serializer is busy with a valid numeral.
   `ITRN_ASSERT(a_pos_in_digit, ser_busy_ff && !ser_err_ff,
                {1'b0, ser_pos_ff} < cur_len)
   // While the receiver stalls, the serializer does not advance.
   `ITRN_ASSERT_NEXT(a_stall_holds, ser_busy_ff && rsp_valid_ff && !rsp_tready,
                     $stable(ser_pos_ff) && $stable(ser_place_ff))

endmodule
